[hw/rtl/rfsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfsr_pkg: shared definitions for the radio file segment reassembler
// Store sizes, index types, division constants and the sequencer states.
// ----------------------------------------------------------------------------
package rfsr_pkg;

	// Number of 5-byte segments the store can hold.
	localparam int SEGMENTS  = 32768;
	localparam int SEG_BYTES = 5;
	localparam int SEG_W     = 8 * SEG_BYTES;

	// Received map is kept as 32-bit words, one bit per segment.
	localparam int MAP_WORD_W = 32;
	localparam int MAP_WORDS  = (SEGMENTS + MAP_WORD_W - 1) / MAP_WORD_W;

	localparam int SEG_AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int MAP_AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int NEED_W = $clog2(SEGMENTS + 1);

	// Largest accepted file size in bytes.
	localparam int MAX_SIZE = SEGMENTS * SEG_BYTES;

	// Division by five as a multiply by a reciprocal. Since 5 * 52429 = 2**18 + 1,
	// the quotient is exact for every dividend below 2**18.
	localparam int RECIP       = 52429;
	localparam int RECIP_SHIFT = 18;

	typedef logic [SEG_AW-1:0]     seg_idx_t;
	typedef logic [MAP_AW-1:0]     map_idx_t;
	typedef logic [MAP_AW:0]       map_cnt_t;
	typedef logic [NEED_W-1:0]     need_t;
	typedef logic [MAP_WORD_W-1:0] map_word_t;
	typedef logic [SEG_W-1:0]      seg_data_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_WAIT,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage : rfsr_pkg
`default_nettype wire

[hw/rtl/rfsr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfsr_ram: generic single-port RAM
// One address per cycle, written on request and always read; read data is registered.
// ----------------------------------------------------------------------------
module rfsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                      wdata,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on request, and register the read data of the addressed entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule : rfsr_ram
`default_nettype wire

[hw/rtl/radio_file_segment_reassembler_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radio_file_segment_reassembler_top: broadcast file segment reassembly
// Stores 5-byte segments, tracks which have arrived and reports completeness.
// ----------------------------------------------------------------------------
// After reset the received map is cleared by a pass over all 1024 map words
// (one map word per cycle) during which no request is accepted; configuration
// writes are taken at any time. Each request then occupies the block on its own:
// store and map access, plus, unless the size is zero or the file has been read
// out, a completeness scan that reads the received map one 32-bit word per cycle
// up to the last word the file spans. A receive request whose toggle bit differs
// from the last one first clears the map again. The result is held in an output
// register, so the next request is taken while a result still waits to be taken.
module radio_file_segment_reassembler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic        toggle,
	input  wire logic [14:0] segment_index,
	input  wire logic [7:0]  block2_low,
	input  wire logic [15:0] block3,
	input  wire logic [15:0] block4,
	// Result channel.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             file_complete,
	output logic             segment_present,
	output logic [7:0]       out_byte0,
	output logic [7:0]       out_byte1,
	output logic [7:0]       out_byte2,
	output logic [7:0]       out_byte3,
	output logic [7:0]       out_byte4,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [17:0] file_size_bytes
);

	rfsr_pkg::state_t state_q, state_d;

	// Configuration and file state.
	logic [17:0]          size_q;
	rfsr_pkg::need_t      need_q;
	rfsr_pkg::map_cnt_t   nwords_q;
	rfsr_pkg::map_word_t  last_mask_q;
	logic                 last_toggle_q;
	logic                 readout_q;

	// Current request.
	logic                 busy_q;
	logic                 kind_q;
	logic                 in_range_q;
	logic [14:0]          seg_addr_q;
	rfsr_pkg::seg_data_t  data_q;
	logic                 present_q;
	rfsr_pkg::seg_data_t  rd_bytes_q;
	logic                 complete_q;

	// Sequencer counters.
	rfsr_pkg::map_idx_t   clr_q;
	rfsr_pkg::map_cnt_t   scan_q;
	logic                 pend_q;
	logic                 pend_last_q;

	// Result register.
	logic                 out_valid_q;
	logic                 out_complete_q;
	logic                 out_present_q;
	rfsr_pkg::seg_data_t  out_bytes_q;

	// Memory ports.
	logic                 store_we;
	rfsr_pkg::seg_idx_t   store_addr;
	rfsr_pkg::seg_data_t  store_rdata;
	logic                 map_we;
	rfsr_pkg::map_idx_t   map_addr;
	rfsr_pkg::map_word_t  map_wdata;
	rfsr_pkg::map_word_t  map_rdata;

	// Derived control.
	logic                 accept;
	logic                 toggle_change;
	logic                 clr_last;
	logic                 out_load;
	logic [14:0]          word_idx;
	rfsr_pkg::map_word_t  seg_bit;
	logic                 seg_hit;
	logic                 scan_issue;
	rfsr_pkg::map_word_t  scan_mask;
	logic                 scan_fail;
	logic                 scan_pass;
	logic                 scan_skip;
	logic [18:0]          size_rnd;
	logic [35:0]          need_prod;
	logic [16:0]          need_rnd;
	logic [4:0]           need_rem;

	assign accept        = in_valid && !in_stall;
	assign toggle_change = (kind == 1'b0) && (toggle != last_toggle_q);
	assign clr_last      = (clr_q == rfsr_pkg::map_idx_t'(rfsr_pkg::MAP_WORDS - 1));
	assign out_load      = (state_q == rfsr_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign word_idx      = seg_addr_q >> 5;
	assign seg_bit       = rfsr_pkg::map_word_t'(1) << seg_addr_q[4:0];
	assign seg_hit       = in_range_q && ((map_rdata & seg_bit) != '0);
	assign scan_skip     = (size_q == '0) || readout_q;

	// Completeness scan: one map word issued per cycle, checked in the cycle after.
	assign scan_issue = (scan_q < nwords_q);
	assign scan_mask  = pend_last_q ? last_mask_q : '1;
	assign scan_fail  = pend_q && ((map_rdata & scan_mask) != scan_mask);
	assign scan_pass  = pend_q && pend_last_q && ((map_rdata & scan_mask) == scan_mask);

	// Segment count ceil(size / 5) and the map words it spans.
	assign size_rnd  = 19'(size_q) + 19'(rfsr_pkg::SEG_BYTES - 1);
	assign need_prod = 36'(size_rnd) * 36'(rfsr_pkg::RECIP);
	assign need_rnd  = 17'(need_q) + 17'(rfsr_pkg::MAP_WORD_W - 1);
	assign need_rem  = need_q[4:0];

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rfsr_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = busy_q ? rfsr_pkg::ST_ACCESS : rfsr_pkg::ST_IDLE;
				end
			end
			rfsr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = toggle_change ? rfsr_pkg::ST_CLEAR : rfsr_pkg::ST_ACCESS;
				end
			end
			rfsr_pkg::ST_ACCESS: begin
				state_d = rfsr_pkg::ST_WAIT;
			end
			rfsr_pkg::ST_WAIT: begin
				state_d = scan_skip ? rfsr_pkg::ST_DONE : rfsr_pkg::ST_SCAN;
			end
			rfsr_pkg::ST_SCAN: begin
				if (scan_fail || scan_pass) begin
					state_d = rfsr_pkg::ST_DONE;
				end
			end
			rfsr_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = rfsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rfsr_pkg::ST_CLEAR;
			end
		endcase
	end

	// Memory and handshake controls for each state.
	always_comb begin
		in_stall   = 1'b1;
		store_we   = 1'b0;
		store_addr = seg_addr_q[rfsr_pkg::SEG_AW-1:0];
		map_we     = 1'b0;
		map_addr   = word_idx[rfsr_pkg::MAP_AW-1:0];
		map_wdata  = '0;
		case (state_q)
			rfsr_pkg::ST_CLEAR: begin
				map_we   = 1'b1;
				map_addr = clr_q;
			end
			rfsr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			rfsr_pkg::ST_ACCESS: begin
				store_we = (kind_q == 1'b0) && in_range_q;
			end
			rfsr_pkg::ST_WAIT: begin
				map_we    = (kind_q == 1'b0) && in_range_q;
				map_wdata = map_rdata | seg_bit;
			end
			rfsr_pkg::ST_SCAN: begin
				map_addr = scan_q[rfsr_pkg::MAP_AW-1:0];
			end
			rfsr_pkg::ST_DONE: begin
				in_stall = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Sequencer state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rfsr_pkg::ST_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			busy_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rfsr_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else begin
				clr_q <= '0;
			end
			if (state_q == rfsr_pkg::ST_SCAN) begin
				if (scan_issue) begin
					scan_q <= scan_q + 1'b1;
				end
				pend_q      <= scan_issue;
				pend_last_q <= scan_issue && (scan_q == nwords_q - 1'b1);
			end else begin
				scan_q      <= '0;
				pend_q      <= 1'b0;
				pend_last_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Configuration register and file-level flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q        <= '0;
			last_toggle_q <= 1'b0;
			readout_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready && (int'(file_size_bytes) <= rfsr_pkg::MAX_SIZE)) begin
				size_q <= file_size_bytes;
			end
			if (accept && (kind == 1'b0)) begin
				last_toggle_q <= toggle;
				if (toggle_change) begin
					readout_q <= 1'b0;
				end
			end
			if ((state_q == rfsr_pkg::ST_ACCESS) && kind_q) begin
				readout_q <= 1'b1;
			end
		end
	end

	// Segment count and last-word mask follow the size register.
	always_ff @(posedge clk) begin
		need_q   <= rfsr_pkg::need_t'(need_prod >> rfsr_pkg::RECIP_SHIFT);
		nwords_q <= rfsr_pkg::map_cnt_t'(need_rnd >> 5);
		if (need_rem == '0) begin
			last_mask_q <= '1;
		end else begin
			last_mask_q <= (rfsr_pkg::map_word_t'(1) << need_rem) - 1'b1;
		end
	end

	// Request payload, read data and completeness flag.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= kind;
			seg_addr_q <= segment_index;
			in_range_q <= (int'(segment_index) < rfsr_pkg::SEGMENTS);
			data_q     <= {block2_low, block3, block4};
			present_q  <= 1'b0;
			rd_bytes_q <= '0;
		end
		if ((state_q == rfsr_pkg::ST_WAIT) && kind_q) begin
			present_q  <= seg_hit;
			rd_bytes_q <= seg_hit ? store_rdata : '0;
		end
		if (state_q == rfsr_pkg::ST_WAIT) begin
			complete_q <= 1'b0;
		end else if (state_q == rfsr_pkg::ST_SCAN) begin
			complete_q <= scan_pass;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_complete_q <= complete_q;
			out_present_q  <= present_q;
			out_bytes_q    <= rd_bytes_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign file_complete   = out_complete_q;
	assign segment_present = out_present_q;
	assign out_byte0       = out_bytes_q[39:32];
	assign out_byte1       = out_bytes_q[31:24];
	assign out_byte2       = out_bytes_q[23:16];
	assign out_byte3       = out_bytes_q[15:8];
	assign out_byte4       = out_bytes_q[7:0];
	assign cfg_ready       = 1'b1;

	// Segment data store.
	rfsr_ram #(
		.WIDTH (rfsr_pkg::SEG_W),
		.DEPTH (rfsr_pkg::SEGMENTS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.addr  (store_addr),
		.wdata (data_q),
		.rdata (store_rdata)
	);

	// Received map, one bit per segment.
	rfsr_ram #(
		.WIDTH (rfsr_pkg::MAP_WORD_W),
		.DEPTH (rfsr_pkg::MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.addr  (map_addr),
		.wdata (map_wdata),
		.rdata (map_rdata)
	);

	// An accepted request holds off the next one.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted while the previous one was still starting");

	// The scan never issues past the words the file spans.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rfsr_pkg::ST_SCAN) |-> (scan_q <= nwords_q))
		else $error("completeness scan ran past the last map word");

	// Neither the map nor the store is written while scanning.
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rfsr_pkg::ST_SCAN) |-> !map_we && !store_we)
		else $error("memory written during the completeness scan");

	// The clearing pass ends after its last map word.
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rfsr_pkg::ST_CLEAR) && clr_last |=> (state_q != rfsr_pkg::ST_CLEAR))
		else $error("clearing pass did not end after the last map word");

endmodule : radio_file_segment_reassembler_top
`default_nettype wire

[bench/radio_file_segment_reassembler_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_file_segment_reassembler_top_test: segment reassembly testbench
// Sends receive and read requests through the request channel. A local copy of
// the segment store, the received map, the toggle and the read-out mark
// predicts every result. Directed corner cases come first, then file passes
// with random content under several file sizes, written while the block idles.
// ----------------------------------------------------------------------------
module radio_file_segment_reassembler_top_test;

	localparam logic KIND_RECEIVE   = 1'b0;
	localparam logic KIND_READ      = 1'b1;
	localparam int   REQUEST_TARGET = 540;
	localparam int   QUIET_TAIL     = 60;
	localparam int   DRAIN_CYCLES   = 2100;

	typedef struct packed {
		logic        kind;
		logic        toggle;
		logic [14:0] addr;
		logic [7:0]  b2;
		logic [15:0] b3;
		logic [15:0] b4;
	} seg_request_t;

	typedef struct packed {
		logic            complete;
		logic            present;
		logic [0:4][7:0] bytes;
	} seg_result_t;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        in_stall;
	logic        kind            = 1'b0;
	logic        toggle          = 1'b0;
	logic [14:0] segment_index   = '0;
	logic [7:0]  block2_low      = '0;
	logic [15:0] block3          = '0;
	logic [15:0] block4          = '0;
	logic        out_valid;
	logic        out_stall       = 1'b0;
	logic        file_complete;
	logic        segment_present;
	logic [7:0]  out_byte0;
	logic [7:0]  out_byte1;
	logic [7:0]  out_byte2;
	logic [7:0]  out_byte3;
	logic [7:0]  out_byte4;
	logic        cfg_valid       = 1'b0;
	logic        cfg_ready;
	logic [17:0] file_size_bytes = '0;

	// Local copy of the reassembly state.
	bit                  map_copy [rfsr_pkg::SEGMENTS];
	rfsr_pkg::seg_data_t store_copy [rfsr_pkg::SEGMENTS];
	bit                  toggle_copy   = 1'b0;
	bit                  read_out_copy = 1'b0;
	int unsigned         size_copy     = 0;

	// Request generation and bookkeeping.
	seg_request_t request_backlog[$];
	seg_result_t  results_due[$];
	seg_request_t active_request;
	int           written_addrs[$];
	bit           gen_toggle      = 1'b0;
	int           requests_queued = 0;
	int           mismatch_count  = 0;
	bit           bursts_on       = 1'b1;
	int           in_gap          = 0;
	int           stall_left      = 0;

	radio_file_segment_reassembler_top dut (.*);

	always #5 clk = ~clk;

	// Applies one request to the local state and returns the result it causes.
	function automatic seg_result_t reassemble_request(seg_request_t rq);
		seg_result_t r;
		int unsigned need;
		r = '0;
		if (rq.kind == KIND_RECEIVE) begin
			// A new file version forgets everything received so far.
			if (rq.toggle != toggle_copy) begin
				foreach (map_copy[i]) map_copy[i] = 1'b0;
				read_out_copy = 1'b0;
			end
			toggle_copy = rq.toggle;
			if (int'(rq.addr) < rfsr_pkg::SEGMENTS) begin
				store_copy[rq.addr] = {rq.b2, rq.b3, rq.b4};
				map_copy[rq.addr]   = 1'b1;
			end
		end else begin
			if (int'(rq.addr) < rfsr_pkg::SEGMENTS && map_copy[rq.addr]) begin
				r.present = 1'b1;
				r.bytes   = store_copy[rq.addr];
			end
			read_out_copy = 1'b1;
		end
		// Complete only with a known size, no read-out, and every leading segment.
		if (!read_out_copy && size_copy != 0) begin
			need = (size_copy + rfsr_pkg::SEG_BYTES - 1) / rfsr_pkg::SEG_BYTES;
			r.complete = (need <= rfsr_pkg::SEGMENTS);
			for (int i = 0; i < need && r.complete; i++) begin
				if (!map_copy[i]) begin
					r.complete = 1'b0;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns: mismatch, %s", $time, what);
		mismatch_count++;
	endtask

	task automatic queue_receive(logic tg, int unsigned a, logic [7:0] b2, logic [15:0] b3,
			logic [15:0] b4);
		seg_request_t rq;
		rq = '{kind: KIND_RECEIVE, toggle: tg, addr: a[14:0], b2: b2, b3: b3, b4: b4};
		request_backlog.push_back(rq);
		written_addrs.push_back(a);
		requests_queued++;
	endtask

	// Reads carry random toggle and block bits, which the block must ignore.
	task automatic queue_read(int unsigned a);
		seg_request_t rq;
		rq = '{kind: KIND_READ, toggle: 1'($urandom_range(0, 1)), addr: a[14:0],
			b2: 8'($urandom), b3: 16'($urandom), b4: 16'($urandom)};
		request_backlog.push_back(rq);
		requests_queued++;
	endtask

	// Only segments written at some point since reset are read.
	task automatic queue_read_stored();
		queue_read(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
	endtask

	// One file delivery: the leading segments in random order, with occasional
	// repeats, stray segments, early reads and version changes mixed in.
	task automatic queue_file_pass(int need);
		int order[$];
		int j;
		int swap;
		for (int i = 0; i < need; i++) begin
			order.push_back(i);
		end
		for (int i = need - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			swap     = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		if ($urandom_range(0, 3) != 0) begin
			gen_toggle = ~gen_toggle;
		end
		foreach (order[i]) begin
			queue_receive(gen_toggle, order[i], 8'($urandom), 16'($urandom), 16'($urandom));
			case ($urandom_range(0, 99))
				0, 1, 2: begin
					queue_receive(gen_toggle, order[i], 8'($urandom), 16'($urandom),
						16'($urandom));
				end
				3, 4, 5: begin
					queue_receive(gen_toggle, $urandom_range(0, rfsr_pkg::SEGMENTS - 1),
						8'($urandom), 16'($urandom), 16'($urandom));
				end
				6: begin
					queue_read_stored();
				end
				7: begin
					gen_toggle = ~gen_toggle;
					queue_receive(gen_toggle, order[$urandom_range(0, need - 1)],
						8'($urandom), 16'($urandom), 16'($urandom));
				end
				default: begin
				end
			endcase
		end
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 3) == 0) begin
				queue_read_stored();
			end else begin
				queue_read($urandom_range(0, need - 1));
			end
		end
	endtask

	// Unstructured traffic: reads of stored segments and writes anywhere.
	task automatic queue_noise(int n);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: begin
					queue_read_stored();
				end
				1: begin
					queue_receive(gen_toggle, $urandom_range(0, rfsr_pkg::SEGMENTS - 1),
						8'($urandom), 16'($urandom), 16'($urandom));
				end
				2: begin
					queue_receive(gen_toggle, $urandom_range(0, 63), 8'($urandom),
						16'($urandom), 16'($urandom));
				end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						gen_toggle = ~gen_toggle;
					end
					queue_receive(gen_toggle, $urandom_range(0, 63), 8'($urandom),
						16'($urandom), 16'($urandom));
				end
			endcase
		end
	endtask

	// Waits until every queued request has been taken and answered.
	task automatic wait_drained();
		do @(negedge clk);
		while (request_backlog.size() != 0 || in_valid || results_due.size() != 0);
	endtask

	// Writes the file size; sizes beyond the store are dropped by the block.
	task automatic write_size(int unsigned v);
		@(posedge clk);
		cfg_valid       <= 1'b1;
		file_size_bytes <= v[17:0];
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (v <= rfsr_pkg::MAX_SIZE) begin
			size_copy = v;
		end
	endtask

	// Request driver: presents queued requests, predicts at each handshake.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid        <= 1'b0;
			kind            <= KIND_RECEIVE;
			toggle          <= 1'b0;
			segment_index   <= '0;
			block2_low      <= '0;
			block3          <= '0;
			block4          <= '0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				results_due.push_back(reassemble_request(active_request));
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (request_backlog.size() > 0) begin
					active_request = request_backlog.pop_front();
					in_valid        <= 1'b1;
					kind            <= active_request.kind;
					toggle          <= active_request.toggle;
					segment_index   <= active_request.addr;
					block2_low      <= active_request.b2;
					block3          <= active_request.b3;
					block4          <= active_request.b4;
					if (bursts_on && $urandom_range(0, 5) == 0) begin
						in_gap = $urandom_range(1, 3);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each taken result and stalls in short bursts.
	always @(posedge clk or negedge arst_n) begin
		seg_result_t     want;
		logic [0:4][7:0] got_bytes;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want      = results_due.pop_front();
					got_bytes = {out_byte0, out_byte1, out_byte2, out_byte3, out_byte4};
					if (file_complete !== want.complete) begin
						report_mismatch($sformatf("file_complete %b, predicted %b",
							file_complete, want.complete));
					end
					if (segment_present !== want.present) begin
						report_mismatch($sformatf("segment_present %b, predicted %b",
							segment_present, want.present));
					end
					for (int k = 0; k < rfsr_pkg::SEG_BYTES; k++) begin
						if (got_bytes[k] !== want.bytes[k]) begin
							report_mismatch($sformatf("out_byte%0d %h, predicted %h", k,
								got_bytes[k], want.bytes[k]));
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (bursts_on && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 3);
				end
			end
		end
	end

	// Stimulus sequence and final verdict.
	initial begin
		int unsigned corner_sizes[5];
		int unsigned size_pick;
		int unsigned need;
		corner_sizes = '{0, 1, 5, 6, rfsr_pkg::MAX_SIZE};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Three segments make a file of twelve bytes.
		write_size(12);
		queue_receive(1'b0, 0, 8'h00, 16'h0000, 16'h0000);
		queue_receive(1'b0, 1, 8'hFF, 16'hFFFF, 16'hFFFF);
		queue_receive(1'b0, rfsr_pkg::SEGMENTS - 1, 8'hA5, 16'h5A5A, 16'hC3C3);
		queue_receive(1'b0, 2, 8'h12, 16'h3456, 16'h789A);
		queue_receive(1'b0, 2, 8'h9A, 16'h7856, 16'h3412);
		// Reading marks the file read out, so completion drops.
		queue_read(0);
		queue_read(1);
		queue_read(rfsr_pkg::SEGMENTS - 1);
		queue_receive(1'b0, 3, 8'h5A, 16'hA5A5, 16'h3C3C);
		// A version change clears the map; old store data must not show.
		queue_receive(1'b1, 15'h5555, 8'h55, 16'hAAAA, 16'h5555);
		queue_read(1);
		queue_receive(1'b1, 0, 8'h01, 16'h0203, 16'h0405);
		queue_receive(1'b1, 1, 8'h06, 16'h0708, 16'h090A);
		queue_receive(1'b1, 2, 8'h0B, 16'h0C0D, 16'h0E0F);
		queue_receive(1'b0, 15'h2AAA, 8'hAA, 16'h5555, 16'hAAAA);
		queue_receive(1'b0, 0, 8'h10, 16'h2030, 16'h4050);
		queue_receive(1'b0, 1, 8'h60, 16'h7080, 16'h90A0);
		queue_receive(1'b0, 2, 8'hB0, 16'hC0D0, 16'hE0F0);
		queue_read(15'h5555);
		queue_read(2);
		gen_toggle = 1'b0;

		// Corner file sizes; the largest one is never filled.
		foreach (corner_sizes[i]) begin
			wait_drained();
			write_size(corner_sizes[i]);
			need = (corner_sizes[i] + rfsr_pkg::SEG_BYTES - 1) / rfsr_pkg::SEG_BYTES;
			queue_file_pass(corner_sizes[i] == 0 ? 3 : (need > 4 ? 4 : need));
		end
		// Oversized writes keep the previous size.
		wait_drained();
		write_size(20);
		write_size((1 << 18) - 1);
		queue_file_pass(4);
		wait_drained();
		write_size(rfsr_pkg::MAX_SIZE + 1);
		queue_file_pass(4);

		// Random phases, each with a fresh file size.
		while (requests_queued < REQUEST_TARGET - QUIET_TAIL) begin
			wait_drained();
			case ($urandom_range(0, 9))
				0: size_pick = 0;
				1: size_pick = $urandom_range(161, 600);
				default: size_pick = $urandom_range(1, 160);
			endcase
			write_size(size_pick);
			if ($urandom_range(0, 5) == 0) begin
				write_size($urandom_range(rfsr_pkg::MAX_SIZE + 1, (1 << 18) - 1));
			end
			if (size_pick == 0) begin
				need = $urandom_range(1, 8);
			end else begin
				need = (size_pick + rfsr_pkg::SEG_BYTES - 1) / rfsr_pkg::SEG_BYTES;
			end
			repeat ($urandom_range(1, 2)) begin
				queue_file_pass(need);
			end
			queue_noise($urandom_range(0, 6));
		end

		// Closing stretch with no idle cycles on either side.
		wait_drained();
		bursts_on = 1'b0;
		if (requests_queued < REQUEST_TARGET) begin
			queue_noise(REQUEST_TARGET - requests_queued);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#60_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
hw/rtl/rfsr_pkg.sv
hw/rtl/rfsr_ram.sv
hw/rtl/radio_file_segment_reassembler_top.sv
bench/radio_file_segment_reassembler_top_test.sv
